// ----- design/cpa_pkg.sv -----
// Package for the complex pointwise ALU: word types, codes and widths.
// No dependencies. Used by every module of the block.
package cpa_pkg;

    localparam int FIELD_W = 32;
    localparam int EPS_W   = 63;
    localparam int DEN_W   = 64;

    localparam logic [EPS_W-1:0] EPS_RESET = 63'd1;

    // operation codes
    localparam logic [1:0] OP_MUL       = 2'd0;
    localparam logic [1:0] OP_MUL_CONJ  = 2'd1;
    localparam logic [1:0] OP_DIV_CUT   = 2'd2;
    localparam logic [1:0] OP_DIV_FLOOR = 2'd3;

    // status codes
    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_CUTOFF = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [FIELD_W-1:0] a_re;
        logic signed [FIELD_W-1:0] a_im;
        logic signed [FIELD_W-1:0] b_re;
        logic signed [FIELD_W-1:0] b_im;
        logic                      last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] res_re;
        logic signed [FIELD_W-1:0] res_im;
        logic [1:0]                status;
        logic                      last_out;
    } out_word_t;

    // control travelling alongside the divider lanes
    typedef struct packed {
        logic      valid;
        logic      is_div;
        logic      neg_re;
        logic      neg_im;
        logic      ovr_re;
        logic      ovr_im;
        out_word_t bypass;
    } div_ctrl_t;

endpackage

// ----- design/complex_pointwise_alu_top.sv -----
// Top level of the complex pointwise ALU: epsilon register, front end, divider chain, output.
// Depends on cpa_pkg, cpa_front and cpa_div_step.
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------
//  item      start, busy            in_word_t (operation, a, b, last_in)
//  result    done (one-cycle strobe) out_word_t (res, status, last_out)
//  config    cfg_we                 cfg_wdata (epsilon, Q31.32)
//
// One item per cycle; busy is always low. An accepted item passes through
// five front-end stages, DATA_WIDTH + 1 divider stages that resolve one
// quotient bit each, and the output register. All operations take the
// same path so results leave in order. Reset clears the valid bits and sets
// epsilon to one LSB (2^-32); the receiver cannot stall, so the pipeline
// always advances.
module complex_pointwise_alu_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  cpa_pkg::in_word_t         item,
    input  logic                      cfg_we,
    input  logic [cpa_pkg::EPS_W-1:0] cfg_wdata,
    output logic                      done,
    output cpa_pkg::out_word_t        result
);
    import cpa_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int QW    = DATA_WIDTH + 1;
    localparam int NSTEP = DATA_WIDTH + 1;
    localparam int WR    = DEN_W + DATA_WIDTH + FRAC_BITS + 1;

    // epsilon register
    logic [EPS_W-1:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg_we)
            eps_reg <= cfg_wdata;
    end

    assign busy = 1'b0;

    // divider chain wiring
    div_ctrl_t        ch_ctrl [0:NSTEP];
    logic [DEN_W-1:0] ch_den  [0:NSTEP];
    logic [WR-1:0]    ch_rre  [0:NSTEP];
    logic [WR-1:0]    ch_rim  [0:NSTEP];
    logic [QW-1:0]    ch_qre  [0:NSTEP];
    logic [QW-1:0]    ch_qim  [0:NSTEP];

    cpa_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .WR         (WR)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (start && !busy),
        .item    (item),
        .epsilon (eps_reg),
        .ctrl    (ch_ctrl[0]),
        .den     (ch_den[0]),
        .num_re  (ch_rre[0]),
        .num_im  (ch_rim[0])
    );

    assign ch_qre[0] = '0;
    assign ch_qim[0] = '0;

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_div
        cpa_div_step #(
            .WR    (WR),
            .QW    (QW),
            .SHIFT (DATA_WIDTH - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_ctrl   (ch_ctrl[k]),
            .up_den    (ch_den[k]),
            .up_rem_re (ch_rre[k]),
            .up_rem_im (ch_rim[k]),
            .up_quo_re (ch_qre[k]),
            .up_quo_im (ch_qim[k]),
            .dn_ctrl   (ch_ctrl[k+1]),
            .dn_den    (ch_den[k+1]),
            .dn_rem_re (ch_rre[k+1]),
            .dn_rem_im (ch_rim[k+1]),
            .dn_quo_re (ch_qre[k+1]),
            .dn_quo_im (ch_qim[k+1])
        );
    end

    // saturate a quotient magnitude: {sat, value}
    function automatic logic [DW:0] pack_quo(input logic neg, input logic ovr,
                                             input logic [QW-1:0] q);
        logic [QW-1:0] lim;
        logic [QW-1:0] negq;
        logic [DW-1:0] minv;
        lim  = QW'(1) << (DW - 1);
        minv = DW'(1) << (DW - 1);
        negq = ~q + 1'b1;
        if (!neg)
        begin
            if (ovr || q > lim - 1'b1)
                return {1'b1, ~minv};
            return {1'b0, q[DW-1:0]};
        end
        if (ovr || q > lim)
            return {1'b1, minv};
        return {1'b0, negq[DW-1:0]};
    endfunction

    // output stage
    div_ctrl_t     fin;
    logic          sat_re, sat_im;
    logic [DW-1:0] v_re, v_im;
    out_word_t     result_next;

    always_comb
    begin
        fin = ch_ctrl[NSTEP];
        {sat_re, v_re} = pack_quo(fin.neg_re, fin.ovr_re, ch_qre[NSTEP]);
        {sat_im, v_im} = pack_quo(fin.neg_im, fin.ovr_im, ch_qim[NSTEP]);
        result_next = fin.bypass;
        if (fin.is_div)
        begin
            result_next.res_re = FIELD_W'(signed'(v_re));
            result_next.res_im = FIELD_W'(signed'(v_im));
            result_next.status = (sat_re || sat_im) ? ST_SAT : ST_NORMAL;
        end
    end

    logic      done_reg;
    out_word_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fin.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- design/cpa_front.sv -----
// Front end of the complex pointwise ALU: split, multiply, sum, select, range check.
// Depends on cpa_pkg. Five register stages feeding the divider chain.
module cpa_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int WR         = 113
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  cpa_pkg::in_word_t          item,
    input  logic [cpa_pkg::EPS_W-1:0]  epsilon,
    output cpa_pkg::div_ctrl_t         ctrl,
    output logic [cpa_pkg::DEN_W-1:0]  den,
    output logic [WR-1:0]              num_re,
    output logic [WR-1:0]              num_im
);
    import cpa_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int MW = 2 * DATA_WIDTH;

    // two's complement to sign and magnitude
    function automatic logic [DW:0] split_mag(input logic [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? (~v + 1'b1) : v;
        return {v[DW-1], m};
    endfunction

    // signed-magnitude add, zero is positive
    function automatic logic [MW:0] sm_add(input logic n1, input logic [MW-1:0] m1,
                                           input logic n2, input logic [MW-1:0] m2);
        logic          n;
        logic [MW-1:0] m;
        if (n1 == n2)
        begin
            n = n1;
            m = m1 + m2;
        end
        else if (m1 >= m2)
        begin
            n = n1;
            m = m1 - m2;
        end
        else
        begin
            n = n2;
            m = m2 - m1;
        end
        if (m == '0)
        begin
            n = 1'b0;
        end
        return {n, m};
    endfunction

    // saturate a product magnitude: {sat, value}
    function automatic logic [DW:0] pack_prod(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] lim;
        logic [MW-1:0] negm;
        logic [DW-1:0] minv;
        lim  = MW'(1) << (DW - 1);
        minv = DW'(1) << (DW - 1);
        negm = ~mag + 1'b1;
        if (!neg)
        begin
            if (mag > lim - 1'b1)
                return {1'b1, ~minv};
            return {1'b0, mag[DW-1:0]};
        end
        if (mag > lim)
            return {1'b1, minv};
        return {1'b0, negm[DW-1:0]};
    endfunction

    // zero divisor: saturate toward the numerator's sign
    function automatic logic [DW-1:0] zero_den(input logic neg, input logic [MW-1:0] mag);
        logic [DW-1:0] minv;
        minv = DW'(1) << (DW - 1);
        if (mag == '0)
            return '0;
        return neg ? minv : ~minv;
    endfunction

    // stage 1: split and sign of each partial product
    logic          nar, nai, nbr, nbi, nbi_c, is_prod1;
    logic [DW-1:0] mar, mai, mbr, mbi;

    always_comb
    begin
        {nar, mar} = split_mag(item.a_re[DW-1:0]);
        {nai, mai} = split_mag(item.a_im[DW-1:0]);
        {nbr, mbr} = split_mag(item.b_re[DW-1:0]);
        {nbi, mbi} = split_mag(item.b_im[DW-1:0]);
        nbi_c = (item.operation == OP_MUL_CONJ && mbi != '0) ? !nbi : nbi;
        is_prod1 = (item.operation == OP_MUL) || (item.operation == OP_MUL_CONJ);
    end

    logic          v1_reg, last1_reg;
    logic [1:0]    op1_reg;
    logic [DW-1:0] mar1_reg, mai1_reg, mbr1_reg, mbi1_reg;
    logic [3:0]    sg1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        op1_reg   <= item.operation;
        last1_reg <= item.last_in;
        mar1_reg  <= mar;
        mai1_reg  <= mai;
        mbr1_reg  <= mbr;
        mbi1_reg  <= mbi;
        // order: rr, ii, ri, ir
        sg1_reg[3] <= nar ^ nbr;
        sg1_reg[2] <= is_prod1 ? !(nai ^ nbi_c) : (nai ^ nbi_c);
        sg1_reg[1] <= is_prod1 ? (nar ^ nbi_c) : !(nar ^ nbi_c);
        sg1_reg[0] <= nai ^ nbr;
    end

    // stage 2: six partial products
    logic          v2_reg, last2_reg;
    logic [1:0]    op2_reg;
    logic [3:0]    sg2_reg;
    logic [MW-1:0] p_rr2_reg, p_ii2_reg, p_ri2_reg, p_ir2_reg, s_r2_reg, s_i2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        op2_reg   <= op1_reg;
        last2_reg <= last1_reg;
        sg2_reg   <= sg1_reg;
        p_rr2_reg <= mar1_reg * mbr1_reg;
        p_ii2_reg <= mai1_reg * mbi1_reg;
        p_ri2_reg <= mar1_reg * mbi1_reg;
        p_ir2_reg <= mai1_reg * mbr1_reg;
        s_r2_reg  <= mbr1_reg * mbr1_reg;
        s_i2_reg  <= mbi1_reg * mbi1_reg;
    end

    // stage 3: sums of products and |b|^2
    logic             v3_reg, last3_reg, nre3_reg, nim3_reg;
    logic [1:0]       op3_reg;
    logic [MW-1:0]    mre3_reg, mim3_reg;
    logic [DEN_W-1:0] den3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        op3_reg   <= op2_reg;
        last3_reg <= last2_reg;
        {nre3_reg, mre3_reg} <= sm_add(sg2_reg[3], p_rr2_reg, sg2_reg[2], p_ii2_reg);
        {nim3_reg, mim3_reg} <= sm_add(sg2_reg[1], p_ri2_reg, sg2_reg[0], p_ir2_reg);
        den3_reg  <= DEN_W'(s_r2_reg) + DEN_W'(s_i2_reg);
    end

    // stage 4: divisor select and results that skip the divider
    logic             lt, is_prod3, sat_re, sat_im, div4;
    logic [DW-1:0]    pv_re, pv_im;
    logic [DEN_W-1:0] dsel;
    out_word_t        byp;

    always_comb
    begin
        lt       = den3_reg < DEN_W'(epsilon);
        is_prod3 = (op3_reg == OP_MUL) || (op3_reg == OP_MUL_CONJ);
        dsel     = (op3_reg == OP_DIV_FLOOR && lt) ? DEN_W'(epsilon) : den3_reg;
        {sat_re, pv_re} = pack_prod(nre3_reg, mre3_reg >> FRAC_BITS);
        {sat_im, pv_im} = pack_prod(nim3_reg, mim3_reg >> FRAC_BITS);
        byp          = '0;
        byp.last_out = last3_reg;
        div4         = 1'b0;
        if (is_prod3)
        begin
            byp.res_re = FIELD_W'(signed'(pv_re));
            byp.res_im = FIELD_W'(signed'(pv_im));
            byp.status = (sat_re || sat_im) ? ST_SAT : ST_NORMAL;
        end
        else if (op3_reg == OP_DIV_CUT && lt)
        begin
            byp.status = ST_CUTOFF;
        end
        else if (dsel == '0)
        begin
            byp.res_re = FIELD_W'(signed'(zero_den(nre3_reg, mre3_reg)));
            byp.res_im = FIELD_W'(signed'(zero_den(nim3_reg, mim3_reg)));
            byp.status = ST_SAT;
        end
        else
        begin
            div4 = 1'b1;
        end
    end

    logic             v4_reg, div4_reg, nre4_reg, nim4_reg;
    logic [MW-1:0]    mre4_reg, mim4_reg;
    logic [DEN_W-1:0] d4_reg;
    out_word_t        byp4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        div4_reg <= div4;
        nre4_reg <= nre3_reg;
        nim4_reg <= nim3_reg;
        mre4_reg <= mre3_reg;
        mim4_reg <= mim3_reg;
        d4_reg   <= dsel;
        byp4_reg <= byp;
    end

    // stage 5: scaled numerators and quotient range check
    logic [WR-1:0] n_re, n_im, lim;
    div_ctrl_t     ctrl_reg;
    logic [WR-1:0] num_re_reg, num_im_reg;
    logic [DEN_W-1:0] den_reg;

    always_comb
    begin
        n_re = WR'(mre4_reg) << FRAC_BITS;
        n_im = WR'(mim4_reg) << FRAC_BITS;
        lim  = WR'(d4_reg) << (DW + 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
        begin
            ctrl_reg.valid  <= v4_reg;
            ctrl_reg.is_div <= div4_reg;
            ctrl_reg.neg_re <= nre4_reg;
            ctrl_reg.neg_im <= nim4_reg;
            ctrl_reg.ovr_re <= n_re >= lim;
            ctrl_reg.ovr_im <= n_im >= lim;
            ctrl_reg.bypass <= byp4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_re_reg <= n_re;
        num_im_reg <= n_im;
        den_reg    <= d4_reg;
    end

    assign ctrl   = ctrl_reg;
    assign den    = den_reg;
    assign num_re = num_re_reg;
    assign num_im = num_im_reg;

endmodule

// ----- design/cpa_div_step.sv -----
// One restoring division stage for both lanes: one quotient bit per lane.
// Depends on cpa_pkg for the control word and divisor width.
module cpa_div_step #(
    parameter int WR    = 113,
    parameter int QW    = 33,
    parameter int SHIFT = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cpa_pkg::div_ctrl_t        up_ctrl,
    input  logic [cpa_pkg::DEN_W-1:0] up_den,
    input  logic [WR-1:0]             up_rem_re,
    input  logic [WR-1:0]             up_rem_im,
    input  logic [QW-1:0]             up_quo_re,
    input  logic [QW-1:0]             up_quo_im,
    output cpa_pkg::div_ctrl_t        dn_ctrl,
    output logic [cpa_pkg::DEN_W-1:0] dn_den,
    output logic [WR-1:0]             dn_rem_re,
    output logic [WR-1:0]             dn_rem_im,
    output logic [QW-1:0]             dn_quo_re,
    output logic [QW-1:0]             dn_quo_im
);
    import cpa_pkg::*;

    logic [WR-1:0] sub;
    logic          ge_re, ge_im;

    // trial subtract of the shifted divisor
    always_comb
    begin
        sub   = WR'(up_den) << SHIFT;
        ge_re = up_rem_re >= sub;
        ge_im = up_rem_im >= sub;
    end

    div_ctrl_t        ctrl_reg;
    logic [DEN_W-1:0] den_reg;
    logic [WR-1:0]    rre_reg, rim_reg;
    logic [QW-1:0]    qre_reg, qim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else
            ctrl_reg <= up_ctrl;
    end

    always_ff @(posedge clk)
    begin
        den_reg <= up_den;
        rre_reg <= ge_re ? (up_rem_re - sub) : up_rem_re;
        rim_reg <= ge_im ? (up_rem_im - sub) : up_rem_im;
        qre_reg <= {up_quo_re[QW-2:0], ge_re};
        qim_reg <= {up_quo_im[QW-2:0], ge_im};
    end

    assign dn_ctrl   = ctrl_reg;
    assign dn_den    = den_reg;
    assign dn_rem_re = rre_reg;
    assign dn_rem_im = rim_reg;
    assign dn_quo_re = qre_reg;
    assign dn_quo_im = qim_reg;

endmodule
